// ===== hdl/ssprd_pkg.sv =====
// Package for the screen stream pixel run decoder.
// Holds the channel item types, register codes and the job type that is
// passed between the front, the queue and the back. No dependencies.
`timescale 1ns / 1ps

package ssprd_pkg;

  // One input item: a stream byte and the restart flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  // One result item: a pixel run.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] run_length;
    logic       last;
  } out_item_t;

  // Stream formats selected by the format_mode register.
  // Codes 5 to 7 are unused.
  typedef enum logic [2:0] {
    ModeRgb565  = 3'd0,
    ModeRgb888  = 3'd1,
    ModeRle2    = 3'd2,
    ModeMonoRaw = 3'd3,
    ModeMonoHex = 3'd4
  } format_mode_e;

  // Configuration register indexes.
  typedef enum logic {
    CfgFormatMode  = 1'b0,
    CfgSwapRedBlue = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] format_mode;
    logic       swap_red_blue;
  } cfg_t;

  // A job is either a single colored run or one byte of eight mono pixels.
  typedef enum logic {
    JobRun  = 1'b0,
    JobMono = 1'b1
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] mono_white;  // one bit per pixel, MSB first, 1 means white
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] run_length;
  } job_t;

  localparam int unsigned QueueDepth = 2;

endpackage

// ===== hdl/screen_stream_pixel_run_decoder_core.sv =====
// Top level of the screen stream pixel run decoder.
// Instantiates ssprd_front, ssprd_queue and ssprd_back; uses ssprd_pkg.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid_i, in_stall_o, in_data_i) takes one stream
// byte per item together with a restart flag. The output channel
// (out_valid_o, out_stall_i, out_data_o) delivers pixel runs, one item per
// run, with last set on the final run that a given byte caused.
// Configuration is written over cfg_valid_i/cfg_ready_o while the block is
// idle; cfg_ready_o is always high. Index 0 is format_mode, 1 swap_red_blue.
// The front decodes a byte in the cycle it is accepted and pushes at most
// one job into a two-entry queue. The back expands the head job into results
// through one output register, one result per cycle unless the receiver
// stalls. A byte that completes a run is written into the queue at the
// accepting edge and reaches the output register from the queue head. Color
// modes sustain one byte per cycle without a stall; mono modes produce eight
// results per pixel byte, which the back sends one by one through its single output register.
// When the receiver stalls, the output register holds its item, the queue
// fills and in_stall_o rises once both entries are taken.
// Reset clears the group assembly state, the queue, the output register
// valid and both configuration registers.

module screen_stream_pixel_run_decoder_core
  import ssprd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t cfg_q;
  logic queue_full;
  logic accept;
  logic job_valid;
  job_t job;
  logic head_valid;
  job_t head;
  logic pop;

  // Configuration registers, written at any time the handshake completes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgFormatMode:  cfg_q.format_mode   <= cfg_data_i[2:0];
        CfgSwapRedBlue: cfg_q.swap_red_blue <= cfg_data_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // A byte is taken whenever the queue has room, even if it yields no job.
  assign in_stall_o = queue_full;
  assign accept     = in_valid_i && !queue_full;

  ssprd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  ssprd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept && job_valid),
    .push_job_i   (job),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ssprd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== hdl/ssprd_front.sv =====
// Front part of the pixel run decoder: assembles stream bytes into groups
// and turns each completed group into at most one job. Depends on ssprd_pkg.
`timescale 1ns / 1ps

module ssprd_front
  import ssprd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     job_valid_o,
  output job_t     job_o
);

  logic [7:0] group_q [3];
  logic [7:0] group_d [3];
  logic [1:0] phase_q, phase_d;
  logic       ext_q, ext_d;
  logic [5:0] color_q, color_d;

  logic [1:0] phase;
  logic       ext;
  logic [5:0] color;
  logic [7:0] d;
  logic [7:0] hex_hi, hex_lo, hex_bits;
  logic [4:0] c565_hi, c565_lo;
  logic [5:0] c565_g;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    expand5 = {v, {3{v[4]}}};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    expand6 = {v, {2{v[5]}}};
  endfunction

  function automatic logic [7:0] hex_nibble(input logic [7:0] c);
    if (c <= 8'h39) begin
      hex_nibble = c - 8'h30;
    end else begin
      hex_nibble = c - 8'h57;
    end
  endfunction

  always_comb begin
    d       = item_i.data_byte;
    // Restart clears partial assembly before the byte is taken.
    phase   = item_i.restart ? 2'd0 : phase_q;
    ext     = item_i.restart ? 1'b0 : ext_q;
    color   = item_i.restart ? 6'd0 : color_q;

    phase_d = phase;
    ext_d   = ext;
    color_d = color;
    group_d = group_q;

    c565_hi  = group_q[0][7:3];
    c565_g   = {group_q[0][2:0], group_q[1][7:5]};
    c565_lo  = group_q[1][4:0];
    hex_hi   = hex_nibble(group_q[0]);
    hex_lo   = hex_nibble(d);
    hex_bits = hex_lo | {hex_hi[3:0], 4'h0};

    job_valid_o      = 1'b0;
    job_o            = '0;
    job_o.kind       = JobRun;

    unique case (format_mode_e'(cfg_i.format_mode))
      ModeRgb565: begin
        if (phase >= 2'd2) begin
          phase_d = 2'd0;
          if (d != 8'd0) begin
            job_valid_o      = 1'b1;
            job_o.red        = expand5(cfg_i.swap_red_blue ? c565_lo : c565_hi);
            job_o.green      = expand6(c565_g);
            job_o.blue       = expand5(cfg_i.swap_red_blue ? c565_hi : c565_lo);
            job_o.run_length = {1'b0, d};
          end
        end else begin
          group_d[phase] = d;
          phase_d        = phase + 2'd1;
        end
      end
      ModeRgb888: begin
        if (phase == 2'd3) begin
          phase_d = 2'd0;
          if (d != 8'd0) begin
            job_valid_o      = 1'b1;
            job_o.red        = group_q[0];
            job_o.green      = group_q[1];
            job_o.blue       = group_q[2];
            job_o.run_length = {1'b0, d};
          end
        end else begin
          group_d[phase] = d;
          phase_d        = phase + 2'd1;
        end
      end
      ModeRle2: begin
        if (ext) begin
          ext_d            = 1'b0;
          job_valid_o      = 1'b1;
          job_o.red        = {color[1:0], 6'd0};
          job_o.green      = {color[3:2], 6'd0};
          job_o.blue       = {color[5:4], 6'd0};
          job_o.run_length = {1'b0, d} + 9'd4;
        end else if (d[7:6] == 2'b11) begin
          // Long run: the color waits for the count extension byte.
          color_d = d[5:0];
          ext_d   = 1'b1;
        end else begin
          job_valid_o      = 1'b1;
          job_o.red        = {d[1:0], 6'd0};
          job_o.green      = {d[3:2], 6'd0};
          job_o.blue       = {d[5:4], 6'd0};
          job_o.run_length = {7'd0, d[7:6]} + 9'd1;
        end
      end
      ModeMonoRaw: begin
        job_valid_o      = 1'b1;
        job_o.kind       = JobMono;
        job_o.mono_white = d;
      end
      ModeMonoHex: begin
        if (phase >= 2'd1) begin
          phase_d          = 2'd0;
          job_valid_o      = 1'b1;
          job_o.kind       = JobMono;
          job_o.mono_white = ~hex_bits;
        end else begin
          group_d[0] = d;
          phase_d    = 2'd1;
        end
      end
      default: begin
        // Unused formats take the byte and change nothing beyond restart.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '{default: '0};
      phase_q <= '0;
      ext_q   <= 1'b0;
      color_q <= '0;
    end else if (accept_i) begin
      group_q <= group_d;
      phase_q <= phase_d;
      ext_q   <= ext_d;
      color_q <= color_d;
    end
  end

endmodule

// ===== hdl/ssprd_queue.sv =====
// Short job queue between the front and the back of the pixel run decoder.
// Depends on ssprd_pkg for the job type and its depth.
`timescale 1ns / 1ps

module ssprd_queue
  import ssprd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  job_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== hdl/ssprd_back.sv =====
// Back part of the pixel run decoder: expands the job at the queue head
// into result items and holds them in the output register.
// Depends on ssprd_pkg.
`timescale 1ns / 1ps

module ssprd_back
  import ssprd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  job_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic [2:0] idx_q, idx_d;
  logic       advance;
  logic       is_last;
  logic [7:0] mono_level;

  assign advance    = !out_valid_q || !out_stall_i;
  // Mono pixels go out MSB first.
  assign mono_level = head_i.mono_white[~idx_q] ? 8'hFF : 8'h00;
  assign is_last    = (head_i.kind == JobRun) || (idx_q == 3'd7);
  assign pop_o      = advance && head_valid_i && is_last;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    if (advance) begin
      out_valid_d = head_valid_i;
      unique case (head_i.kind)
        JobRun: begin
          out_d.red        = head_i.red;
          out_d.green      = head_i.green;
          out_d.blue       = head_i.blue;
          out_d.run_length = head_i.run_length;
        end
        JobMono: begin
          out_d.red        = mono_level;
          out_d.green      = mono_level;
          out_d.blue       = mono_level;
          out_d.run_length = 9'd1;
        end
        default: begin
          out_d = out_q;
        end
      endcase
      out_d.last = is_last;
      if (head_valid_i) begin
        idx_d = is_last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== test/screen_stream_pixel_run_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for screen_stream_pixel_run_decoder_core: a directed
// table, a back-pressure phase and random byte streams in every format, checked
// by a built-in decoder. Depends on ssprd_pkg and the core RTL only.

module screen_stream_pixel_run_decoder_core_tb;
  import ssprd_pkg::*;

  // Stimulus sizing and timing.
  localparam int RandItems    = 75;
  localparam int SettleCycles = 8;
  localparam int RxHoldCycles = 300;
  localparam int TimeoutNs    = 5_000_000;

  // Row marker: the expected runs of this row come from the decoder below.
  localparam int FromModel = -1;

  // Format codes that the package leaves unnamed; the block ignores bytes in them.
  localparam logic [2:0] ModeSpareLow  = 3'd5;
  localparam logic [2:0] ModeSpareHigh = 3'd7;

  logic       clk;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_item_t  out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;

  screen_stream_pixel_run_decoder_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 8 ns clock, low first so the first rising edge falls at 4 ns.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model state. It mirrors the configuration registers and the group
  // assembly of the block, and is advanced once for every accepted item.
  // ---------------------------------------------------------------------------
  logic [2:0] mode_reg;
  logic       swap_reg;
  logic [7:0] asm_bytes [3];
  logic [1:0] asm_count;
  logic       esc_pending;
  logic [5:0] esc_color;

  // Runs still owed by the block, oldest first.
  out_item_t pending_runs [$];
  int        err_cnt = 0;

  // Number of long hold-offs the stimulus has asked the receiver for.
  int hold_req = 0;
  // While set, neither side inserts random idle cycles; requested hold-offs still apply.
  bit calm = 1'b0;

  // Directed table. Rows with n_typed of 0 or 1 carry their expectation typed
  // in; FromModel rows are left to the decoder.
  typedef struct {
    logic [2:0] mode;
    logic       swap;
    in_item_t   item;
    int         n_typed;
    out_item_t  typed;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_row(input logic [2:0] mode, input logic swap,
                                  input logic [7:0] d, input logic rs, input int n_typed,
                                  input logic [23:0] rgb, input logic [8:0] len);
    dir_row_t row;
    row.mode    = mode;
    row.swap    = swap;
    row.item    = '{data_byte: d, restart: rs};
    row.n_typed = n_typed;
    row.typed   = '{red: rgb[23:16], green: rgb[15:8], blue: rgb[7:0],
                    run_length: len, last: 1'b1};
    dir_rows.push_back(row);
  endfunction

  // Five-bit channel to eight bits: shift up and fill the low bits when the
  // top bit is set.
  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, 3'b000} + (v[4] ? 8'h07 : 8'h00);
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, 2'b00} + (v[5] ? 8'h03 : 8'h00);
  endfunction

  // Hex character to nibble. Characters outside the hex set wrap modulo 256,
  // so the later OR can carry junk into the high nibble.
  function automatic logic [7:0] hex_val(input logic [7:0] c);
    return (c <= "9") ? c - "0" : c + 8'd10 - "a";
  endfunction

  // Advances the decoder by one byte and returns the runs that byte causes.
  function automatic int decode_byte(input in_item_t it, output out_item_t runs [8]);
    logic [7:0]  d;
    logic [15:0] word;
    logic [4:0]  r5;
    logic [4:0]  b5;
    logic [7:0]  bits;
    logic [7:0]  v;
    logic        white_one;
    logic        mono;
    int          n;
    int          i;
    d    = it.data_byte;
    n    = 0;
    mono = 1'b0;
    bits = '0;
    white_one = 1'b0;
    for (i = 0; i < 8; i++) runs[i] = '0;

    // A restart drops any partial group and any pending RLE extension.
    if (it.restart) begin
      asm_count   = 2'd0;
      esc_pending = 1'b0;
      esc_color   = '0;
    end

    case (mode_reg)
      ModeRgb565: begin
        if (asm_count >= 2'd2) begin
          word      = {asm_bytes[0], asm_bytes[1]};
          asm_count = 2'd0;
          // A zero count swallows the whole group.
          if (d != 8'h00) begin
            r5 = swap_reg ? word[4:0] : word[15:11];
            b5 = swap_reg ? word[15:11] : word[4:0];
            runs[0] = '{red: widen5(r5), green: widen6(word[10:5]), blue: widen5(b5),
                        run_length: {1'b0, d}, last: 1'b0};
            n = 1;
          end
        end else begin
          asm_bytes[asm_count] = d;
          asm_count = asm_count + 2'd1;
        end
      end
      ModeRgb888: begin
        if (asm_count >= 2'd3) begin
          asm_count = 2'd0;
          if (d != 8'h00) begin
            runs[0] = '{red: asm_bytes[0], green: asm_bytes[1], blue: asm_bytes[2],
                        run_length: {1'b0, d}, last: 1'b0};
            n = 1;
          end
        end else begin
          asm_bytes[asm_count] = d;
          asm_count = asm_count + 2'd1;
        end
      end
      ModeRle2: begin
        if (esc_pending) begin
          esc_pending = 1'b0;
          runs[0] = '{red: {esc_color[1:0], 6'd0}, green: {esc_color[3:2], 6'd0},
                      blue: {esc_color[5:4], 6'd0}, run_length: {1'b0, d} + 9'd4,
                      last: 1'b0};
          n = 1;
        end else if (d[7:6] == 2'b11) begin
          // Escape code: hold the color, the next byte carries the count.
          esc_color   = d[5:0];
          esc_pending = 1'b1;
        end else begin
          runs[0] = '{red: {d[1:0], 6'd0}, green: {d[3:2], 6'd0}, blue: {d[5:4], 6'd0},
                      run_length: {7'd0, d[7:6]} + 9'd1, last: 1'b0};
          n = 1;
        end
      end
      ModeMonoRaw: begin
        bits      = d;
        white_one = 1'b1;
        mono      = 1'b1;
      end
      ModeMonoHex: begin
        if (asm_count >= 2'd1) begin
          bits      = (hex_val(asm_bytes[0]) << 4) | hex_val(d);
          asm_count = 2'd0;
          white_one = 1'b0;
          mono      = 1'b1;
        end else begin
          asm_bytes[0] = d;
          asm_count    = 2'd1;
        end
      end
      default: begin
        // Unused formats leave everything as it is.
      end
    endcase

    if (mono) begin
      for (i = 0; i < 8; i++) begin
        v = (bits[7 - i] == white_one) ? 8'hFF : 8'h00;
        runs[i] = '{red: v, green: v, blue: v, run_length: 9'd1, last: 1'b0};
      end
      n = 8;
    end

    if (n > 0) runs[n - 1].last = 1'b1;
    return n;
  endfunction

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 0;
    if (pick < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item after an optional gap and books its expected runs once
  // it is taken. Valid stays high when the next item follows without a gap.
  task automatic send_byte(input in_item_t it, input int n_typed, input out_item_t typed);
    int        gap;
    int        n;
    int        i;
    out_item_t runs [8];
    gap = calm ? 0 : idle_cycles();
    if (gap > 0) begin
      @(negedge clk);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    n = decode_byte(it, runs);
    if (n_typed == FromModel) begin
      for (i = 0; i < n; i++) pending_runs.push_back(runs[i]);
    end else if (n_typed == 1) begin
      pending_runs.push_back(typed);
    end
  endtask

  // Stops offering items and waits until every owed run has arrived, then
  // lets the block settle for items that cause no run.
  task automatic wait_drained();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    if (idx == CfgFormatMode) mode_reg = val[2:0];
    else swap_reg = val[0];
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // Writes the registers that differ, or both if asked, once the block is idle.
  // Unused upper data bits get random values since only the low bits are meaningful.
  task automatic set_cfg(input logic [2:0] mode, input logic swap, input bit both);
    logic [7:0] junk;
    wait_drained();
    junk = 8'($urandom);
    if (both || mode != mode_reg) write_reg(CfgFormatMode, {junk[7:3], mode});
    junk = 8'($urandom);
    if (both || swap != swap_reg) write_reg(CfgSwapRedBlue, {junk[7:1], swap});
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. Stalls at random, and on request holds off for a long stretch so
  // that the queue inside the block fills and the input side stalls.
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int hold_left;
    int stall_left;
    int hold_seen;
    hold_left   = 0;
    stall_left  = 0;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen && hold_left == 0) begin
        hold_seen = hold_req;
        hold_left = RxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
      end
    end
  end

  // Every accepted run is matched against the oldest owed one.
  always @(posedge clk) begin : run_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected run, got %02h %02h %02h len %0d last %0b", $time,
                 out_data_o.red, out_data_o.green, out_data_o.blue,
                 out_data_o.run_length, out_data_o.last);
        err_cnt++;
      end else begin
        want = pending_runs.pop_front();
        if (out_data_o !== want) begin
          $display(
            "%0t: exp %02h%02h%02h len %0d last %0b, got %02h%02h%02h len %0d last %0b",
            $time, want.red, want.green, want.blue, want.run_length, want.last,
            out_data_o.red, out_data_o.green, out_data_o.blue,
            out_data_o.run_length, out_data_o.last);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, a back-pressure phase, then random streams.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t   row;
    in_item_t   item;
    logic [7:0] grp_q [$];
    logic [7:0] b;
    logic [2:0] mode;
    int         sent;
    int         pick;
    int         nib;
    bit         rs_first;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgFormatMode;
    cfg_data_i  = '0;
    mode_reg    = ModeRgb565;
    swap_reg    = 1'b0;
    asm_bytes   = '{default: '0};
    asm_count   = '0;
    esc_pending = 1'b0;
    esc_color   = '0;

    // RGB565 extremes: all ones widens to full white, then the darkest run.
    add_row(ModeRgb565, 1'b0, 8'hFF, 1'b1, 0, 24'h0, 9'd0);
    add_row(ModeRgb565, 1'b0, 8'hFF, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb565, 1'b0, 8'hFF, 1'b0, 1, 24'hFFFFFF, 9'd255);
    add_row(ModeRgb565, 1'b0, 8'h00, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb565, 1'b0, 8'h00, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb565, 1'b0, 8'h01, 1'b0, 1, 24'h000000, 9'd1);
    // A zero count drops the group without a run.
    add_row(ModeRgb565, 1'b0, 8'h12, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb565, 1'b0, 8'h34, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb565, 1'b0, 8'h00, 1'b0, 0, 24'h0, 9'd0);
    // With the swap set, the top five bits land in blue.
    add_row(ModeRgb565, 1'b1, 8'hF8, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb565, 1'b1, 8'h00, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb565, 1'b1, 8'h05, 1'b0, 1, 24'h0000FF, 9'd5);
    // RGB888 quad passes the bytes straight through.
    add_row(ModeRgb888, 1'b0, 8'h11, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb888, 1'b0, 8'h22, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb888, 1'b0, 8'h33, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb888, 1'b0, 8'hFF, 1'b0, 1, 24'h112233, 9'd255);
    // Two-bit RLE: shortest and longest plain runs, then the escape with the
    // largest extension count.
    add_row(ModeRle2, 1'b0, 8'h00, 1'b0, 1, 24'h000000, 9'd1);
    add_row(ModeRle2, 1'b0, 8'hBF, 1'b0, 1, 24'hC0C0C0, 9'd3);
    add_row(ModeRle2, 1'b0, 8'hC5, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRle2, 1'b0, 8'hFF, 1'b0, 1, 24'h404000, 9'd259);
    add_row(ModeMonoRaw, 1'b0, 8'hA5, 1'b0, FromModel, 24'h0, 9'd0);
    // Hex mono fed two characters outside the hex set.
    add_row(ModeMonoHex, 1'b0, "z", 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeMonoHex, 1'b0, "!", 1'b0, FromModel, 24'h0, 9'd0);
    // The highest unused format swallows the byte.
    add_row(ModeSpareHigh, 1'b0, 8'h42, 1'b0, 0, 24'h0, 9'd0);
    // A format change mid-group keeps the held bytes: two RGB888 bytes are
    // completed by an RGB565 count.
    add_row(ModeRgb888, 1'b0, 8'h40, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb888, 1'b0, 8'h80, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRgb565, 1'b0, 8'h09, 1'b0, FromModel, 24'h0, 9'd0);
    // Restart cancels a pending RLE extension, so the byte is a plain code.
    add_row(ModeRle2, 1'b0, 8'hC3, 1'b0, 0, 24'h0, 9'd0);
    add_row(ModeRle2, 1'b0, 8'h10, 1'b1, FromModel, 24'h0, 9'd0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.mode != mode_reg || row.swap != swap_reg) set_cfg(row.mode, row.swap, 1'b0);
      send_byte(row.item, row.n_typed, row.typed);
    end

    // Back-pressure: the receiver holds off while mono bytes keep coming, so
    // the block fills up and stalls its input. Then the sender waits for all
    // owed runs before going on.
    calm = 1'b1;
    set_cfg(ModeMonoRaw, 1'b0, 1'b1);
    hold_req++;
    repeat (6) begin
      item.data_byte = 8'($urandom);
      item.restart   = 1'($urandom_range(0, 1));
      send_byte(item, FromModel, '0);
    end
    wait_drained();

    // Random phases. Most traffic is well-formed groups for the chosen format,
    // with some truncated groups and some raw noise mixed in.
    sent = 0;
    while (sent < RandItems) begin
      pick = $urandom_range(0, 20);
      if (pick < 20) mode = 3'(pick % 5);
      else mode = 3'(ModeSpareLow + $urandom_range(0, 2));
      calm = ($urandom_range(0, 3) == 0);
      set_cfg(mode, 1'($urandom_range(0, 1)), 1'b1);
      repeat ((mode == ModeMonoRaw || mode == ModeMonoHex) ? 3 : 6) begin
        grp_q.delete();
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          repeat ($urandom_range(1, 3)) grp_q.push_back(8'($urandom));
        end else begin
          case (mode)
            ModeRgb565: begin
              grp_q.push_back(8'($urandom));
              grp_q.push_back(8'($urandom));
              grp_q.push_back(($urandom_range(0, 5) == 0) ? 8'h00
                                                          : 8'($urandom_range(1, 255)));
            end
            ModeRgb888: begin
              repeat (3) grp_q.push_back(8'($urandom));
              grp_q.push_back(($urandom_range(0, 5) == 0) ? 8'h00
                                                          : 8'($urandom_range(1, 255)));
            end
            ModeRle2: begin
              b = 8'($urandom);
              grp_q.push_back(b);
              if (b[7:6] == 2'b11) grp_q.push_back(8'($urandom));
            end
            ModeMonoHex: begin
              repeat (2) begin
                nib = $urandom_range(0, 15);
                grp_q.push_back(8'((nib < 10) ? "0" + nib : "a" + nib - 10));
              end
            end
            default: begin
              grp_q.push_back(8'($urandom));
            end
          endcase
          // A broken group: its tail goes missing.
          if (pick == 1 && grp_q.size() > 1) void'(grp_q.pop_back());
        end
        rs_first = (pick == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 2) == 0);
        foreach (grp_q[j]) begin
          item.data_byte = grp_q[j];
          if (j == 0) item.restart = rs_first;
          else item.restart = (pick == 0) ? 1'($urandom_range(0, 1)) : 1'b0;
          send_byte(item, FromModel, '0);
          if (mode <= ModeMonoHex) sent++;
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin : watchdog
    #(TimeoutNs);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== screen_stream_pixel_run_decoder_core.f =====
hdl/ssprd_pkg.sv
hdl/ssprd_front.sv
hdl/ssprd_queue.sv
hdl/ssprd_back.sv
hdl/screen_stream_pixel_run_decoder_core.sv
test/screen_stream_pixel_run_decoder_core_tb.sv
